>>> design/triangle_unit_normal_defines.svh
// ----------------------------------------------------------------------------
// triangle_unit_normal_defines.svh
// Assertion macros for the triangle unit normal block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TUN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tun assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define TUN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tun assertion failed");

`endif

>>> design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and control types of the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 15;
    localparam int OUT_BITS      = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

endpackage

>>> design/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Accept triangles, form edges and exact cross product, classify degenerate.
// ----------------------------------------------------------------------------
module tun_front #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tri_valid,
    output logic                        tri_stall,
    input  logic [COORD_BITS-1:0]       first_x,
    input  logic [COORD_BITS-1:0]       first_y,
    input  logic [COORD_BITS-1:0]       first_z,
    input  logic [COORD_BITS-1:0]       second_x,
    input  logic [COORD_BITS-1:0]       second_y,
    input  logic [COORD_BITS-1:0]       second_z,
    input  logic [COORD_BITS-1:0]       third_x,
    input  logic [COORD_BITS-1:0]       third_y,
    input  logic [COORD_BITS-1:0]       third_z,
    input  tun_pkg::queue_status_t      q_status,
    output logic                        push,
    output logic [3*(2*COORD_BITS+2)+3:0] push_word
);

    localparam int E = COORD_BITS + 1;
    localparam int P = 2 * E;
    localparam int X = P + 1;
    localparam int M = P;

    logic         en;
    logic         v0_reg, v1_reg, v2_reg;
    logic [E-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [P-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [X-1:0] cx, cy, cz, ncx, ncy, ncz;
    logic [M-1:0] mx_next, my_next, mz_next;
    logic [M-1:0] mx_reg, my_reg, mz_reg;
    logic         sx_reg, sy_reg, sz_reg, dg_reg;

    function automatic logic [E-1:0] edge_of(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
        return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    assign en        = !v2_reg || !q_status.full;
    assign tri_stall = !en;
    assign push      = v2_reg && !q_status.full;
    assign push_word = {dg_reg, sz_reg, sy_reg, sx_reg, mz_reg, my_reg, mx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= tri_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        cx  = {p0_reg[P-1], p0_reg} - {p1_reg[P-1], p1_reg};
        cy  = {p2_reg[P-1], p2_reg} - {p3_reg[P-1], p3_reg};
        cz  = {p4_reg[P-1], p4_reg} - {p5_reg[P-1], p5_reg};
        ncx = -cx;
        ncy = -cy;
        ncz = -cz;
        mx_next = cx[X-1] ? ncx[M-1:0] : cx[M-1:0];
        my_next = cy[X-1] ? ncy[M-1:0] : cy[M-1:0];
        mz_next = cz[X-1] ? ncz[M-1:0] : cz[M-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= edge_of(second_x, first_x);
            ay_reg <= edge_of(second_y, first_y);
            az_reg <= edge_of(second_z, first_z);
            bx_reg <= edge_of(third_x, first_x);
            by_reg <= edge_of(third_y, first_y);
            bz_reg <= edge_of(third_z, first_z);
            p0_reg <= P'($signed(ay_reg) * $signed(bz_reg));
            p1_reg <= P'($signed(az_reg) * $signed(by_reg));
            p2_reg <= P'($signed(az_reg) * $signed(bx_reg));
            p3_reg <= P'($signed(ax_reg) * $signed(bz_reg));
            p4_reg <= P'($signed(ax_reg) * $signed(by_reg));
            p5_reg <= P'($signed(ay_reg) * $signed(bx_reg));
            mx_reg <= mx_next;
            my_reg <= my_next;
            mz_reg <= mz_next;
            sx_reg <= cx[X-1];
            sy_reg <= cy[X-1];
            sz_reg <= cz[X-1];
            dg_reg <= (cx == '0) && (cy == '0) && (cz == '0);
        end
    end

endmodule

>>> design/tun_queue.sv
// ----------------------------------------------------------------------------
// tun_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module tun_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tun_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tun_pkg::queue_ctl_t    ctl,
    input  logic [WIDTH-1:0]       wr_word,
    output logic [WIDTH-1:0]       rd_word,
    output tun_pkg::queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW-1:0]    rp_next;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rd_word_reg;
    logic             do_push, do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = ctl.push && !status.full;
    assign do_pop       = ctl.pop && !status.empty;
    assign rp_next      = do_pop ? bump(rp_reg) : rp_reg;
    assign rd_word      = rd_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= bump(wp_reg);
            rp_reg <= rp_next;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wp_reg] <= wr_word;
        if (do_push && (wp_reg == rp_next))
            rd_word_reg <= wr_word;
        else
            rd_word_reg <= mem[rp_next];
    end

endmodule

>>> design/tun_back.sv
// ----------------------------------------------------------------------------
// tun_back
// Squares, pipelined integer root, pipelined division, output register.
// ----------------------------------------------------------------------------
module tun_back #(
    parameter int COORD_BITS    = tun_pkg::COORD_BITS,
    parameter int FRACTION_BITS = tun_pkg::FRACTION_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tun_pkg::queue_status_t         q_status,
    input  logic [3*(2*COORD_BITS+2)+3:0]  pop_word,
    output logic                           pop,
    output logic                           norm_valid,
    input  logic                           norm_stall,
    output logic [tun_pkg::OUT_BITS-1:0]   normal_x,
    output logic [tun_pkg::OUT_BITS-1:0]   normal_y,
    output logic [tun_pkg::OUT_BITS-1:0]   normal_z,
    output logic                           degenerate
);

    localparam int M  = 2 * (COORD_BITS + 1);
    localparam int W  = 3 * M + 4;
    localparam int S  = 2 * M + 2;
    localparam int R  = M + 1;
    localparam int D  = R + 1;
    localparam int F  = FRACTION_BITS;
    localparam int Q  = F + 1;
    localparam int OB = tun_pkg::OUT_BITS;
    localparam int SX = 3 * M;
    localparam int DG = 3 * M + 3;

    logic         en;
    logic         vsq_reg;
    logic [W-1:0] psq_reg;
    logic [2*M-1:0] sqx_reg, sqy_reg, sqz_reg;

    logic         v_reg   [0:R];
    logic [W-1:0] pay_reg [0:R];
    logic [S-1:0] rem_reg [0:R];
    logic [R-1:0] root_reg [0:R];

    logic         dv_reg  [0:F];
    logic [W-1:0] dpay_reg [0:F];
    logic [R-1:0] len_reg [0:F];
    logic [D-1:0] dr_reg  [0:F][0:2];
    logic [Q-1:0] dq_reg  [0:F][0:2];

    logic          ov_reg;
    logic [OB-1:0] ox_reg, oy_reg, oz_reg;
    logic          odg_reg;

    assign en         = !ov_reg || !norm_stall;
    assign pop        = en && !q_status.empty;
    assign norm_valid = ov_reg;
    assign normal_x   = ox_reg;
    assign normal_y   = oy_reg;
    assign normal_z   = oz_reg;
    assign degenerate = odg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vsq_reg <= 1'b0;
        else if (en)
            vsq_reg <= !q_status.empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            psq_reg <= pop_word;
            sqx_reg <= pop_word[M-1:0] * pop_word[M-1:0];
            sqy_reg <= pop_word[2*M-1:M] * pop_word[2*M-1:M];
            sqz_reg <= pop_word[3*M-1:2*M] * pop_word[3*M-1:2*M];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= vsq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0]  <= psq_reg;
            rem_reg[0]  <= S'(sqx_reg) + S'(sqy_reg) + S'(sqz_reg);
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < R; k++)
    begin : g_root
        localparam int B = R - 1 - k;
        logic [S-1:0] trial;
        logic         take;

        assign trial = ({{(S-R){1'b0}}, root_reg[k]} << (B + 1))
                     | ({{(S-1){1'b0}}, 1'b1} << (2 * B));
        assign take  = rem_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pay_reg[k+1]  <= pay_reg[k];
                rem_reg[k+1]  <= take ? rem_reg[k] - trial : rem_reg[k];
                root_reg[k+1] <= take ? (root_reg[k] | (R'(1) << B)) : root_reg[k];
            end
        end
    end

    for (genvar j = 0; j <= F; j++)
    begin : g_div
        logic         vin;
        logic [W-1:0] pin;
        logic [R-1:0] lin;

        if (j == 0)
        begin : g_first
            assign vin = v_reg[R];
            assign pin = pay_reg[R];
            assign lin = root_reg[R];
        end
        else
        begin : g_next
            assign vin = dv_reg[j-1];
            assign pin = dpay_reg[j-1];
            assign lin = len_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (en)
                dv_reg[j] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dpay_reg[j] <= pin;
                len_reg[j]  <= lin;
            end
        end

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [D-1:0] rin;
            logic [Q-1:0] qin;
            logic         ge;

            if (j == 0)
            begin : g_first
                assign rin = {{(D-M){1'b0}}, pay_reg[R][l*M +: M]};
                assign qin = '0;
            end
            else
            begin : g_next
                assign rin = {dr_reg[j-1][l][D-2:0], 1'b0};
                assign qin = dq_reg[j-1][l];
            end

            assign ge = rin >= {1'b0, lin};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dr_reg[j][l] <= ge ? rin - {1'b0, lin} : rin;
                    dq_reg[j][l] <= {qin[Q-2:0], ge};
                end
            end
        end
    end

    function automatic logic [OB-1:0] finish(input logic [Q-1:0] q, input logic neg);
        logic [Q+OB-1:0] ext;
        logic [Q+OB-1:0] nq;
        logic [Q+OB-1:0] lext;
        logic [Q-1:0]    lim;
        ext  = {{OB{1'b0}}, q};
        nq   = -ext;
        lim  = {1'b0, {F{1'b1}}};
        lext = {{OB{1'b0}}, lim};
        if (neg)
            return nq[OB-1:0];
        else if (q > lim)
            return lext[OB-1:0];
        else
            return ext[OB-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_reg[F];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            odg_reg <= dpay_reg[F][DG];
            if (dpay_reg[F][DG])
            begin
                ox_reg <= '0;
                oy_reg <= '0;
                oz_reg <= '0;
            end
            else
            begin
                ox_reg <= finish(dq_reg[F][0], dpay_reg[F][SX]);
                oy_reg <= finish(dq_reg[F][1], dpay_reg[F][SX+1]);
                oz_reg <= finish(dq_reg[F][2], dpay_reg[F][SX+2]);
            end
        end
    end

endmodule

>>> design/triangle_unit_normal.sv
// A triangle passes the front registers, the queue, the squaring and sum registers, the
// root stages, the division stages and the output register before norm_valid rises.
// Throughput: one triangle per cycle unless stalled, one root bit and one quotient bit per stage.
// The queue of QUEUE_DEPTH words lets the front keep accepting while the back stalls.
// Reset clears all valid bits and queue pointers; there is no clearing pass.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit normal of a triangle as signed Q1.FRACTION_BITS components.
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_defines.svh"

module triangle_unit_normal #(
    parameter int COORD_BITS    = tun_pkg::COORD_BITS,
    parameter int FRACTION_BITS = tun_pkg::FRACTION_BITS,
    parameter int QUEUE_DEPTH   = tun_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tri_valid,
    output logic                         tri_stall,
    input  logic [COORD_BITS-1:0]        first_x,
    input  logic [COORD_BITS-1:0]        first_y,
    input  logic [COORD_BITS-1:0]        first_z,
    input  logic [COORD_BITS-1:0]        second_x,
    input  logic [COORD_BITS-1:0]        second_y,
    input  logic [COORD_BITS-1:0]        second_z,
    input  logic [COORD_BITS-1:0]        third_x,
    input  logic [COORD_BITS-1:0]        third_y,
    input  logic [COORD_BITS-1:0]        third_z,
    output logic                         norm_valid,
    input  logic                         norm_stall,
    output logic [tun_pkg::OUT_BITS-1:0] normal_x,
    output logic [tun_pkg::OUT_BITS-1:0] normal_y,
    output logic [tun_pkg::OUT_BITS-1:0] normal_z,
    output logic                         degenerate
);

    localparam int W = 3 * (2 * COORD_BITS + 2) + 4;

    tun_pkg::queue_status_t q_status;
    tun_pkg::queue_ctl_t    q_ctl;
    logic [W-1:0]           push_word;
    logic [W-1:0]           pop_word;
    logic                   push;
    logic                   pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    tun_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .third_x   (third_x),
        .third_y   (third_y),
        .third_z   (third_z),
        .q_status  (q_status),
        .push      (push),
        .push_word (push_word)
    );

    tun_queue #(
        .WIDTH (W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .wr_word (push_word),
        .rd_word (pop_word),
        .status  (q_status)
    );

    tun_back #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_word   (pop_word),
        .pop        (pop),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

    `TUN_ASSERT_IMPL(a_degen_zero, norm_valid && degenerate, (normal_x | normal_y | normal_z) == '0)
    `TUN_ASSERT_IMPL(a_queue_sane, 1'b1, !(q_status.full && q_status.empty))
    `TUN_ASSERT_IMPL(a_full_stalls, q_status.full, !push)
    `TUN_ASSERT_NEXT(a_pop_fills, pop && q_status.empty, 1'b0)

endmodule

>>> bench/tb_triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Streams triangles through the unit normal block under varying idle and stall
// pressure and compares every normal word against an exact integer prediction.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = tun_pkg::COORD_BITS;
    localparam int FRACTION_BITS = tun_pkg::FRACTION_BITS;
    localparam int OUT_BITS      = tun_pkg::OUT_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t v [9];
    } triangle_t;

    typedef struct {
        logic [OUT_BITS-1:0] nx;
        logic [OUT_BITS-1:0] ny;
        logic [OUT_BITS-1:0] nz;
        logic                degen;
    } normal_t;

    logic clk;
    logic rst_n;
    logic tri_valid;
    logic tri_stall;
    coord_t first_x, first_y, first_z, second_x, second_y, second_z;
    coord_t third_x, third_y, third_z;
    logic norm_valid;
    logic norm_stall;
    logic [OUT_BITS-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    triangle_t pending_tris [$];
    normal_t   expected_normals [$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_send;
    bit        tri_taken;

    triangle_unit_normal DUT (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .norm_valid(norm_valid), .norm_stall(norm_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    function automatic logic [OUT_BITS-1:0] unit_component(
        longint signed c, logic [127:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] one;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        one = 128'(1) << FRACTION_BITS;
        q = 0;
        r = mag;
        if (r >= len)
        begin
            q = 1;
            r = r - len;
        end
        for (int i = 0; i < FRACTION_BITS; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= len)
            begin
                r = r - len;
                q[0] = 1'b1;
            end
        end
        if (c < 0)
            return OUT_BITS'(-q);
        if (q >= one)
            q = one - 1;
        return OUT_BITS'(q);
    endfunction

    function automatic normal_t face_normal(triangle_t t);
        longint signed ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [127:0] mx, my, mz;
        logic [127:0] sum;
        logic [127:0] root;
        logic [127:0] cand;
        normal_t n;
        ax = longint'(t.v[3]) - t.v[0];
        ay = longint'(t.v[4]) - t.v[1];
        az = longint'(t.v[5]) - t.v[2];
        bx = longint'(t.v[6]) - t.v[0];
        by = longint'(t.v[7]) - t.v[1];
        bz = longint'(t.v[8]) - t.v[2];
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        mx = (cx < 0) ? 128'(-cx) : 128'(cx);
        my = (cy < 0) ? 128'(-cy) : 128'(cy);
        mz = (cz < 0) ? 128'(-cz) : 128'(cz);
        sum = mx * mx + my * my + mz * mz;
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (128'(1) << b);
            if (cand * cand <= sum)
                root = cand;
        end
        if (root == 0)
        begin
            n.nx = 0;
            n.ny = 0;
            n.nz = 0;
            n.degen = 1'b1;
        end
        else
        begin
            n.nx = unit_component(cx, root);
            n.ny = unit_component(cy, root);
            n.nz = unit_component(cz, root);
            n.degen = 1'b0;
        end
        return n;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_BITS-1:0] got,
                                   logic [OUT_BITS-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic add_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                           int c0, int c1, int c2);
        triangle_t t;
        t.v[0] = coord_t'(a0); t.v[1] = coord_t'(a1); t.v[2] = coord_t'(a2);
        t.v[3] = coord_t'(b0); t.v[4] = coord_t'(b1); t.v[5] = coord_t'(b2);
        t.v[6] = coord_t'(c0); t.v[7] = coord_t'(c1); t.v[8] = coord_t'(c2);
        pending_tris = {pending_tris, t};
    endtask

    function automatic coord_t random_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 31)) - 16;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_tris.size() != 0 || expected_normals.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tri_taken <= 1'b0;
        else
            tri_taken <= tri_valid && !tri_stall;
    end

    // driver: launch at falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid <= 1'b0;
        end
        else if (!tri_valid || tri_taken)
        begin
            if (pending_tris.size() != 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                triangle_t t;
                t = pending_tris.pop_front();
                expected_normals = {expected_normals, face_normal(t)};
                first_x  <= t.v[0]; first_y  <= t.v[1]; first_z  <= t.v[2];
                second_x <= t.v[3]; second_y <= t.v[4]; second_z <= t.v[5];
                third_x  <= t.v[6]; third_y  <= t.v[7]; third_z  <= t.v[8];
                tri_valid <= 1'b1;
            end
            else
                tri_valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_stall <= 1'b0;
        else
            norm_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor: compare at rising edge
    always @(posedge clk)
    begin
        if (rst_n && norm_valid && !norm_stall)
        begin
            if (expected_normals.size() == 0)
            begin
                report_mismatch("unexpected word", normal_x, '0);
            end
            else
            begin
                normal_t e;
                e = expected_normals.pop_front();
                if (normal_x !== e.nx)
                    report_mismatch("normal_x", normal_x, e.nx);
                if (normal_y !== e.ny)
                    report_mismatch("normal_y", normal_y, e.ny);
                if (normal_z !== e.nz)
                    report_mismatch("normal_z", normal_z, e.nz);
                if (degenerate !== e.degen)
                    report_mismatch("degenerate", OUT_BITS'(degenerate), OUT_BITS'(e.degen));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb_triangle_unit_normal: FAIL");
        $finish;
    end

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        int mode;
        triangle_t t;
        phase_idle  = '{0, 86, 0, 28};
        phase_stall = '{0, 0, 86, 28};
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_send = 1'b0;
        rst_n = 1'b0;
        tri_valid = 1'b0;
        norm_stall = 1'b0;
        {first_x, first_y, first_z, second_x, second_y, second_z} = '0;
        {third_x, third_y, third_z} = '0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(5, 5, 5, 5, 5, 5, 9, 1, 2);
        add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6);
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
        add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_tri(0, 0, 0, 0, 0, 1, 0, 1, 0);
        add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_tri(0, 0, 0, 1, 1, 0, 0, 1, 1);
        add_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                -32768, 32767, -32768);
        add_tri(32767, 32767, 32767, -32768, 32767, 32767,
                32767, -32768, 32767);
        add_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                -32768, 32767, 32767);
        add_tri(32767, -32768, 32767, -32768, 32767, -32768,
                32767, 32767, -32768);
        add_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                -32768, -32768, 32767);
        add_tri(-1, -1, -1, 0, 0, 0, 1, 2, 3);
        add_tri(3, 4, 0, 0, 0, 0, 7, 1, 5);
        add_tri(0, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int i = 0; i < 410; i++)
            begin
                mode = $urandom_range(0, 3);
                for (int k = 0; k < 9; k++)
                    t.v[k] = random_coord(mode);
                if ($urandom_range(0, 19) == 0)
                    for (int k = 0; k < 3; k++)
                        t.v[6 + k] = t.v[k] + (t.v[3 + k] - t.v[k]) * 2;
                pending_tris = {pending_tris, t};
                if (ph == 1 && i == 200)
                begin
                    hold_send = 1'b1;
                    while (expected_normals.size() != 0)
                        @(posedge clk);
                    hold_send = 1'b0;
                end
            end
        end
        recv_stall_pct = 28;
        send_idle_pct = 0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_normals.size() == 0)
            $display("tb_triangle_unit_normal: PASS");
        else
            $display("tb_triangle_unit_normal: FAIL");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/tun_pkg.sv
design/tun_front.sv
design/tun_queue.sv
design/tun_back.sv
design/triangle_unit_normal.sv
bench/tb_triangle_unit_normal.sv
